// ===== rtl/pfe_pkg.sv =====
// Package for the postfix expression evaluator.
// Holds the word types, token and status codes and sizing constants used by all modules.
// Depends on nothing.
`default_nettype none

package pfe_pkg;

  // Sizing constants.
  localparam int unsigned EXPR_LENGTH = 16;
  localparam int unsigned STACK_SLOTS = 16;
  localparam int unsigned DEPTH_W     = $clog2(STACK_SLOTS + 1);
  localparam int unsigned CNT_W       = $clog2(EXPR_LENGTH + 1);
  localparam int unsigned TOKQ_DEPTH  = 2;
  localparam int unsigned TOKQ_PTR_W  = $clog2(TOKQ_DEPTH);
  localparam int unsigned TOKQ_CNT_W  = $clog2(TOKQ_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;

  // Token kinds.
  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_OPER  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  // Operator codes; the codes above select are unknown.
  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_NEG = 4'd5,
    OP_EQ  = 4'd6,
    OP_NE  = 4'd7,
    OP_GT  = 4'd8,
    OP_LT  = 4'd9,
    OP_GE  = 4'd10,
    OP_LE  = 4'd11,
    OP_SEL = 4'd12
  } op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_e;

  // Input word.
  typedef struct packed {
    kind_e                      token_kind;
    logic [3:0]                 operator_code;
    logic signed [DATA_W-1:0]   operand_value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic signed [DATA_W-1:0]   result_value;
    status_e                    status;
  } out_word_t;

  // Classified token passed from the front to the back.
  typedef struct packed {
    kind_e              kind;
    logic [3:0]         op;
    logic [DATA_W-1:0]  value;
    logic [1:0]         need;
    logic               unknown;
    logic               divmod;
  } tok_t;

  // Divider request and response.
  typedef struct packed {
    logic               start;
    logic [DATA_W-1:0]  dividend;
    logic [DATA_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DATA_W-1:0]  quotient;
    logic [DATA_W-1:0]  remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/postfix_expression_evaluator_top.sv =====
// Postfix expression evaluator: a front end with a two-word token queue and a stack back end.
// The word that ends an expression passes the token queue; its result is then registered.
// Throughput: one word per cycle for pushes and for operators other than divide and modulo,
// unless a result word waits for the result slot; divide and modulo wait for the bit-serial
// 32-bit back-end divider. Reset: rst_ni is asynchronous, active low; it empties the token queue
// and result slot and starts a new expression. Depends on pfe_pkg, pfe_front and pfe_back.
`default_nettype none

module postfix_expression_evaluator_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push,
  output logic                full,
  input  pfe_pkg::in_word_t   in_word_i,
  output logic                empty,
  input  wire                 pop,
  output pfe_pkg::out_word_t  out_word_o
);

  logic          tok_valid;
  logic          tok_pop;
  pfe_pkg::tok_t tok;

  // Accept and classify input words.
  pfe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  // Evaluate tokens and present results.
  pfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_pop_o   (tok_pop),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ===== rtl/pfe_front.sv =====
// Front end of the postfix expression evaluator: accepts input words, classifies them
// and holds them in a short token queue for the back end. Depends on pfe_pkg.
`default_nettype none

module pfe_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push,
  output logic                full,
  input  pfe_pkg::in_word_t   in_word_i,
  output logic                tok_valid_o,
  output pfe_pkg::tok_t       tok_o,
  input  wire                 tok_pop_i
);

  pfe_pkg::tok_t tokq_mem [pfe_pkg::TOKQ_DEPTH];

  logic [pfe_pkg::TOKQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [pfe_pkg::TOKQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [pfe_pkg::TOKQ_CNT_W-1:0] cnt_q, cnt_d;

  pfe_pkg::tok_t cls;
  logic          wr_en;
  logic          rd_en;

  // Classify the incoming word: operand count and special operators.
  always_comb begin
    cls.kind    = in_word_i.token_kind;
    cls.op      = in_word_i.operator_code;
    cls.value   = in_word_i.operand_value;
    cls.unknown = (in_word_i.operator_code > pfe_pkg::OP_SEL);
    cls.divmod  = (in_word_i.operator_code == pfe_pkg::OP_DIV) ||
                  (in_word_i.operator_code == pfe_pkg::OP_MOD);
    if (in_word_i.operator_code == pfe_pkg::OP_NEG) begin
      cls.need = 2'd1;
    end else if (in_word_i.operator_code == pfe_pkg::OP_SEL) begin
      cls.need = 2'd3;
    end else begin
      cls.need = 2'd2;
    end
  end

  // Queue handshakes and pointer updates.
  assign full        = (cnt_q == pfe_pkg::TOKQ_CNT_W'(pfe_pkg::TOKQ_DEPTH));
  assign tok_valid_o = (cnt_q != '0);
  assign tok_o       = tokq_mem[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = tok_pop_i && tok_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Token storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tokq_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfe_div.sv =====
// Iterative unsigned 32-bit divider, one quotient bit per cycle.
// Used by the back end for divide and modulo. Depends on pfe_pkg.
`default_nettype none

module pfe_div (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  pfe_pkg::div_req_t  req_i,
  output pfe_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned STEP_W = $clog2(pfe_pkg::DATA_W);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [STEP_W-1:0]          step_q, step_d;
  logic [pfe_pkg::DATA_W-1:0] rem_q, rem_d;
  logic [pfe_pkg::DATA_W-1:0] quo_q, quo_d;
  logic [pfe_pkg::DATA_W-1:0] dvs_q, dvs_d;
  logic [pfe_pkg::DATA_W:0]   trial;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  assign trial = {rem_q, quo_q[pfe_pkg::DATA_W-1]} - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = '1;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!trial[pfe_pkg::DATA_W]) begin
        rem_d = trial[pfe_pkg::DATA_W-1:0];
        quo_d = {quo_q[pfe_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[pfe_pkg::DATA_W-2:0], quo_q[pfe_pkg::DATA_W-1]};
        quo_d = {quo_q[pfe_pkg::DATA_W-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

// ===== rtl/pfe_back.sv =====
// Back end of the postfix expression evaluator: carries out tokens on the operand stack,
// tracks the expression length and error state, and holds the result word.
// Depends on pfe_pkg and pfe_div.
`default_nettype none

module pfe_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 tok_valid_i,
  input  pfe_pkg::tok_t       tok_i,
  output logic                tok_pop_o,
  output logic                empty,
  input  wire                 pop,
  output pfe_pkg::out_word_t  out_word_o
);

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_e;

  state_e state_q, state_d;

  // Operand stack as a shift line: entry 0 is the top.
  logic [pfe_pkg::DATA_W-1:0]  stk_q [pfe_pkg::STACK_SLOTS];
  logic [pfe_pkg::DATA_W-1:0]  stk_d [pfe_pkg::STACK_SLOTS];
  logic                        stk_we;

  logic [pfe_pkg::DEPTH_W-1:0] depth_q, depth_d;
  logic [pfe_pkg::CNT_W-1:0]   cnt_q, cnt_d, cnt_n;
  logic                        disc_q, disc_d;
  logic                        out_valid_q, out_valid_d;
  pfe_pkg::out_word_t          out_q, emit_word;
  logic                        emit;
  logic                        mod_q, mod_d, qneg_q, qneg_d, rneg_q, rneg_d;

  logic [pfe_pkg::DATA_W-1:0]  a, b, c, alu_r, div_val;
  logic [pfe_pkg::DATA_W-1:0]  mag_a, mag_b;
  pfe_pkg::status_e            tok_st;
  logic [pfe_pkg::DATA_W-1:0]  tok_val;
  logic [1:0]                  tok_npop;
  logic                        start_div;
  logic                        out_free;
  logic                        lim;

  logic                        fin_go;
  pfe_pkg::status_e            fin_st;
  logic [1:0]                  fin_pop;
  logic [pfe_pkg::DATA_W-1:0]  fin_val;

  pfe_pkg::div_req_t           div_req;
  pfe_pkg::div_rsp_t           div_rsp;

  assign b = stk_q[0];
  assign a = stk_q[1];
  assign c = stk_q[2];
  assign mag_a = a[pfe_pkg::DATA_W-1] ? (pfe_pkg::DATA_W'(0) - a) : a;
  assign mag_b = b[pfe_pkg::DATA_W-1] ? (pfe_pkg::DATA_W'(0) - b) : b;

  assign out_free = !out_valid_q || pop;
  assign cnt_n    = cnt_q + 1'b1;
  assign lim      = (cnt_n >= pfe_pkg::CNT_W'(pfe_pkg::EXPR_LENGTH));

  // Divider for divide and modulo.
  assign div_req.start    = start_div && (state_q == S_IDLE) && tok_valid_i && !disc_q;
  assign div_req.dividend = mag_a;
  assign div_req.divisor  = mag_b;

  pfe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sign fix-up of the divider result.
  always_comb begin
    if (mod_q) begin
      div_val = rneg_q ? (pfe_pkg::DATA_W'(0) - div_rsp.remainder) : div_rsp.remainder;
    end else begin
      div_val = qneg_q ? (pfe_pkg::DATA_W'(0) - div_rsp.quotient) : div_rsp.quotient;
    end
  end

  // Operators computed without the divider.
  always_comb begin
    case (pfe_pkg::op_e'(tok_i.op))
      pfe_pkg::OP_ADD: alu_r = a + b;
      pfe_pkg::OP_SUB: alu_r = a - b;
      pfe_pkg::OP_MUL: alu_r = a * b;
      pfe_pkg::OP_NEG: alu_r = pfe_pkg::DATA_W'(0) - b;
      pfe_pkg::OP_EQ:  alu_r = pfe_pkg::DATA_W'(a == b);
      pfe_pkg::OP_NE:  alu_r = pfe_pkg::DATA_W'(a != b);
      pfe_pkg::OP_GT:  alu_r = pfe_pkg::DATA_W'($signed(a) > $signed(b));
      pfe_pkg::OP_LT:  alu_r = pfe_pkg::DATA_W'($signed(a) < $signed(b));
      pfe_pkg::OP_GE:  alu_r = pfe_pkg::DATA_W'($signed(a) >= $signed(b));
      pfe_pkg::OP_LE:  alu_r = pfe_pkg::DATA_W'($signed(a) <= $signed(b));
      pfe_pkg::OP_SEL: alu_r = (c != '0) ? a : b;
      default:         alu_r = '0;
    endcase
  end

  // Status and pushed value of a push or operator token.
  always_comb begin
    tok_st    = pfe_pkg::ST_OK;
    tok_val   = alu_r;
    tok_npop  = tok_i.need;
    start_div = 1'b0;
    if (tok_i.kind == pfe_pkg::KIND_OPER) begin
      if (tok_i.unknown) begin
        tok_st = pfe_pkg::ST_UNKNOWN;
      end else if (depth_q < pfe_pkg::DEPTH_W'(tok_i.need)) begin
        tok_st = pfe_pkg::ST_UNDERFLOW;
      end else if (tok_i.divmod && (b == '0)) begin
        tok_st = pfe_pkg::ST_DIVZERO;
      end else begin
        start_div = tok_i.divmod;
      end
    end else begin
      tok_npop = 2'd0;
      tok_val  = (tok_i.kind == pfe_pkg::KIND_VALUE) ? tok_i.value : '0;
      if (depth_q == pfe_pkg::DEPTH_W'(pfe_pkg::STACK_SLOTS)) begin
        tok_st = pfe_pkg::ST_OVERFLOW;
      end
    end
  end

  // Sequencing of tokens, expression bookkeeping and result emission.
  always_comb begin
    state_d   = state_q;
    depth_d   = depth_q;
    cnt_d     = cnt_q;
    disc_d    = disc_q;
    mod_d     = mod_q;
    qneg_d    = qneg_q;
    rneg_d    = rneg_q;
    tok_pop_o = 1'b0;
    emit      = 1'b0;
    emit_word = '{result_value: '0, status: pfe_pkg::ST_OK};
    stk_we    = 1'b0;
    fin_go    = 1'b0;
    fin_st    = pfe_pkg::ST_OK;
    fin_pop   = 2'd0;
    fin_val   = '0;

    case (state_q)
      S_IDLE: begin
        if (tok_valid_i) begin
          if (tok_i.kind == pfe_pkg::KIND_END) begin
            if (disc_q) begin
              tok_pop_o = 1'b1;
              depth_d   = '0;
              cnt_d     = '0;
              disc_d    = 1'b0;
            end else if (out_free) begin
              tok_pop_o = 1'b1;
              emit      = 1'b1;
              if (depth_q == '0) begin
                emit_word.status = pfe_pkg::ST_UNDERFLOW;
              end else begin
                emit_word.result_value = b;
              end
              depth_d = '0;
              cnt_d   = '0;
            end
          end else if (disc_q) begin
            tok_pop_o = 1'b1;
            if (lim) begin
              depth_d = '0;
              cnt_d   = '0;
              disc_d  = 1'b0;
            end else begin
              cnt_d = cnt_n;
            end
          end else if (start_div) begin
            tok_pop_o = 1'b1;
            state_d   = S_DIV;
            mod_d     = (tok_i.op == pfe_pkg::OP_MOD);
            qneg_d    = a[pfe_pkg::DATA_W-1] ^ b[pfe_pkg::DATA_W-1];
            rneg_d    = a[pfe_pkg::DATA_W-1];
          end else begin
            fin_go  = 1'b1;
            fin_st  = tok_st;
            fin_pop = tok_npop;
            fin_val = tok_val;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          fin_go  = 1'b1;
          fin_pop = 2'd2;
          fin_val = div_val;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Completion of a push or operator token.
    if (fin_go && (out_free || ((fin_st == pfe_pkg::ST_OK) && !lim))) begin
      if (state_q == S_IDLE) begin
        tok_pop_o = 1'b1;
      end else begin
        state_d = S_IDLE;
      end
      if (fin_st != pfe_pkg::ST_OK) begin
        emit             = 1'b1;
        emit_word.status = fin_st;
        depth_d          = '0;
        if (lim) begin
          cnt_d  = '0;
          disc_d = 1'b0;
        end else begin
          cnt_d  = cnt_n;
          disc_d = 1'b1;
        end
      end else begin
        stk_we  = 1'b1;
        depth_d = depth_q - pfe_pkg::DEPTH_W'(fin_pop) + 1'b1;
        if (lim) begin
          emit                   = 1'b1;
          emit_word.result_value = fin_val;
          depth_d                = '0;
          cnt_d                  = '0;
        end else begin
          cnt_d = cnt_n;
        end
      end
    end

    // Result slot occupancy.
    out_valid_d = out_valid_q && !pop;
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  // Next stack contents: pop the operands and push the new top.
  always_comb begin
    stk_d[0] = fin_val;
    for (int i = 1; i < pfe_pkg::STACK_SLOTS; i++) begin
      stk_d[i] = stk_q[i];
      case (fin_pop)
        2'd0: stk_d[i] = stk_q[i-1];
        2'd2: begin
          if (i < pfe_pkg::STACK_SLOTS - 1) begin
            stk_d[i] = stk_q[i+1];
          end
        end
        2'd3: begin
          if (i < pfe_pkg::STACK_SLOTS - 2) begin
            stk_d[i] = stk_q[i+2];
          end
        end
        default: stk_d[i] = stk_q[i];
      endcase
    end
  end

  // Control state and result slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      cnt_q       <= '0;
      disc_q      <= 1'b0;
      out_valid_q <= 1'b0;
      mod_q       <= 1'b0;
      qneg_q      <= 1'b0;
      rneg_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      cnt_q       <= cnt_d;
      disc_q      <= disc_d;
      out_valid_q <= out_valid_d;
      mod_q       <= mod_d;
      qneg_q      <= qneg_d;
      rneg_q      <= rneg_d;
    end
  end

  // Stack entries and result word need no reset.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_q <= stk_d;
    end
    if (emit) begin
      out_q <= emit_word;
    end
  end

  assign empty      = !out_valid_q;
  assign out_word_o = out_q;

endmodule

`default_nettype wire
